>>> hw/rtl/ar3d_pkg.sv
// ----------------------------------------------------------------------------
// ar3d_pkg - shared types and constants for the 3D axis rotation block
// Holds the request codes, the axis codes, the CORDIC datapath width, the gain
// constant and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package ar3d_pkg;

	// Request codes
	localparam logic [2:0] REQ_FRAME_X = 3'd0;
	localparam logic [2:0] REQ_FRAME_Y = 3'd1;
	localparam logic [2:0] REQ_FRAME_Z = 3'd2;
	localparam logic [2:0] REQ_VEC_X   = 3'd3;
	localparam logic [2:0] REQ_VEC_Y   = 3'd4;
	localparam logic [2:0] REQ_VEC_Z   = 3'd5;

	// Axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// CORDIC datapath width: Q2.30 values with headroom for gain growth
	localparam int CW = 34;
	// Maximum number of CORDIC stages covered by the table
	localparam int MAX_STAGES = 30;
	// CORDIC gain K = 0.60725... in Q2.30
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	// Per-item side information carried alongside the CORDIC
	typedef struct packed {
		logic               rot;
		logic               frame;
		logic               flip;
		logic [1:0]         axis;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
	} side_t;

	// atan(2^-i) as a binary angle, 2^31 = pi
	function automatic logic signed [CW-1:0] atan_val(input logic [4:0] idx);
		logic signed [CW-1:0] v;
		case (idx)
			5'd0:    v = 34'sd536870912;
			5'd1:    v = 34'sd316933406;
			5'd2:    v = 34'sd167458907;
			5'd3:    v = 34'sd85004756;
			5'd4:    v = 34'sd42667331;
			5'd5:    v = 34'sd21354465;
			5'd6:    v = 34'sd10679838;
			5'd7:    v = 34'sd5340245;
			5'd8:    v = 34'sd2670163;
			5'd9:    v = 34'sd1335087;
			5'd10:   v = 34'sd667544;
			5'd11:   v = 34'sd333772;
			5'd12:   v = 34'sd166886;
			5'd13:   v = 34'sd83443;
			5'd14:   v = 34'sd41722;
			5'd15:   v = 34'sd20861;
			5'd16:   v = 34'sd10430;
			5'd17:   v = 34'sd5215;
			5'd18:   v = 34'sd2608;
			5'd19:   v = 34'sd1304;
			5'd20:   v = 34'sd652;
			5'd21:   v = 34'sd326;
			5'd22:   v = 34'sd163;
			5'd23:   v = 34'sd81;
			5'd24:   v = 34'sd41;
			5'd25:   v = 34'sd20;
			5'd26:   v = 34'sd10;
			5'd27:   v = 34'sd5;
			5'd28:   v = 34'sd3;
			5'd29:   v = 34'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/axis_rotation_3d.sv
// Pipeline (stage count clamped to 1..30): one input register, one register per
// CORDIC stage, then pair select, multiply and round/saturate registers.
// Throughput: one word per cycle; a stall on the output freezes the whole pipe.
// Reset (arst_n low, asynchronous) clears the valid bits only.
// ----------------------------------------------------------------------------
// axis_rotation_3d - elementary rotation of a 3D Q16.16 vector
// Rotates the vector about X, Y or Z (frame or vector rotation) using a fully
// unrolled CORDIC for cos/sin and a 2x2 multiply, with output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_rotation_3d #(
	parameter int DATA_WIDTH    = 32,
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         req_type,
	input  wire logic signed [31:0] vec_x,
	input  wire logic signed [31:0] vec_y,
	input  wire logic signed [31:0] vec_z,
	input  wire logic signed [31:0] angle,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic signed [31:0]      out_z,
	output logic                    saturated
);

	localparam int CW  = ar3d_pkg::CW;
	localparam int W   = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 2) ? 2 : DATA_WIDTH);
	localparam int SH  = 32 - W;
	localparam int NS  = (CORDIC_STAGES < 1) ? 1 :
		((CORDIC_STAGES > ar3d_pkg::MAX_STAGES) ? ar3d_pkg::MAX_STAGES : CORDIC_STAGES);
	localparam int LAT = NS + 4;
	localparam int PW  = 32 + CW;
	localparam int SW  = PW + 1;
	localparam int RW  = SW - 30;
	localparam logic signed [RW-1:0] HI = (RW'(1) <<< (W - 1)) - RW'(1);
	localparam logic signed [RW-1:0] LO = -HI - RW'(1);

	// Sign-extend the low W bits of a component
	function automatic logic signed [31:0] sext_w(input logic [31:0] v);
		logic signed [31:0] t;
		t = $signed(v << SH);
		return t >>> SH;
	endfunction

	// Clip a rounded result to W-bit signed range; top bit flags a clip
	function automatic logic [32:0] clip_w(input logic signed [RW-1:0] v);
		logic [32:0] r;
		if (v > HI) begin
			r = {1'b1, HI[31:0]};
		end else if (v < LO) begin
			r = {1'b1, LO[31:0]};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	logic adv;
	logic [LAT-1:0] vld_s;

	// Whole pipe holds while the output word waits
	assign adv      = !(vld_s[LAT-1] && out_stall);
	assign in_stall = !adv;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	// Decode request and reduce angle into [-pi/2, pi/2)
	ar3d_pkg::side_t in_side;
	logic signed [CW-1:0] z_in;

	always_comb begin
		in_side.rot   = 1'b1;
		in_side.frame = 1'b0;
		in_side.axis  = ar3d_pkg::AXIS_X;
		case (req_type) inside
			ar3d_pkg::REQ_FRAME_X: begin
				in_side.frame = 1'b1;
				in_side.axis  = ar3d_pkg::AXIS_X;
			end
			ar3d_pkg::REQ_FRAME_Y: begin
				in_side.frame = 1'b1;
				in_side.axis  = ar3d_pkg::AXIS_Y;
			end
			ar3d_pkg::REQ_FRAME_Z: begin
				in_side.frame = 1'b1;
				in_side.axis  = ar3d_pkg::AXIS_Z;
			end
			ar3d_pkg::REQ_VEC_X: begin
				in_side.axis = ar3d_pkg::AXIS_X;
			end
			ar3d_pkg::REQ_VEC_Y: begin
				in_side.axis = ar3d_pkg::AXIS_Y;
			end
			ar3d_pkg::REQ_VEC_Z: begin
				in_side.axis = ar3d_pkg::AXIS_Z;
			end
			default: begin
				in_side.rot = 1'b0;
			end
		endcase
		in_side.flip = angle[31] ^ angle[30];
		in_side.vx   = sext_w(vec_x);
		in_side.vy   = sext_w(vec_y);
		in_side.vz   = sext_w(vec_z);
		z_in = CW'($signed({angle[31] ^ in_side.flip, angle[30:0]}));
	end

	// CORDIC pipeline: index 0 is the input register
	logic signed [CW-1:0] cx_s [0:NS];
	logic signed [CW-1:0] cy_s [0:NS];
	logic signed [CW-1:0] cz_s [0:NS];
	ar3d_pkg::side_t      side_s [0:NS];

	// Load the input word
	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s[0]   <= ar3d_pkg::CORDIC_GAIN;
			cy_s[0]   <= '0;
			cz_s[0]   <= z_in;
			side_s[0] <= in_side;
		end
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < NS; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!cz_s[i][CW-1]) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - ar3d_pkg::atan_val(5'(i));
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + ar3d_pkg::atan_val(5'(i));
				end
				side_s[i+1] <= side_s[i];
			end
		end
	end

	// Fix signs of cos/sin and pick the rotated pair
	logic signed [CW-1:0] cos_sa;
	logic signed [CW-1:0] sin_sa;
	logic signed [31:0]   a_sa;
	logic signed [31:0]   b_sa;
	ar3d_pkg::side_t      side_sa;

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_sa  <= side_s[NS].flip ? -cx_s[NS] : cx_s[NS];
			sin_sa  <= (side_s[NS].flip ^ side_s[NS].frame) ? -cy_s[NS] : cy_s[NS];
			side_sa <= side_s[NS];
			case (side_s[NS].axis)
				ar3d_pkg::AXIS_Y: begin
					a_sa <= side_s[NS].vz;
					b_sa <= side_s[NS].vx;
				end
				ar3d_pkg::AXIS_Z: begin
					a_sa <= side_s[NS].vx;
					b_sa <= side_s[NS].vy;
				end
				default: begin
					a_sa <= side_s[NS].vy;
					b_sa <= side_s[NS].vz;
				end
			endcase
		end
	end

	// Form the four products
	logic signed [PW-1:0] ac_sb;
	logic signed [PW-1:0] bs_sb;
	logic signed [PW-1:0] as_sb;
	logic signed [PW-1:0] bc_sb;
	ar3d_pkg::side_t      side_sb;

	always_ff @(posedge clk) begin
		if (adv) begin
			ac_sb   <= a_sa * cos_sa;
			bs_sb   <= b_sa * sin_sa;
			as_sb   <= a_sa * sin_sa;
			bc_sb   <= b_sa * cos_sa;
			side_sb <= side_sa;
		end
	end

	// Combine, round half up and saturate
	logic signed [SW-1:0] na;
	logic signed [SW-1:0] nb;
	logic [32:0]          ca;
	logic [32:0]          cb;
	logic signed [31:0]   rx;
	logic signed [31:0]   ry;
	logic signed [31:0]   rz;
	logic                 rsat;

	always_comb begin
		na = $signed({ac_sb[PW-1], ac_sb}) - $signed({bs_sb[PW-1], bs_sb})
			+ (SW'(1) <<< 29);
		nb = $signed({as_sb[PW-1], as_sb}) + $signed({bc_sb[PW-1], bc_sb})
			+ (SW'(1) <<< 29);
		ca = clip_w($signed(na[SW-1:30]));
		cb = clip_w($signed(nb[SW-1:30]));
		rx   = side_sb.vx;
		ry   = side_sb.vy;
		rz   = side_sb.vz;
		rsat = 1'b0;
		if (side_sb.rot) begin
			rsat = ca[32] | cb[32];
			case (side_sb.axis)
				ar3d_pkg::AXIS_Y: begin
					rz = $signed(ca[31:0]);
					rx = $signed(cb[31:0]);
				end
				ar3d_pkg::AXIS_Z: begin
					rx = $signed(ca[31:0]);
					ry = $signed(cb[31:0]);
				end
				default: begin
					ry = $signed(ca[31:0]);
					rz = $signed(cb[31:0]);
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_x     <= rx;
			out_y     <= ry;
			out_z     <= rz;
			saturated <= rsat;
		end
	end

	assign out_valid = vld_s[LAT-1];

endmodule

`default_nettype wire
